// ===== hw/rtl/slc_pkg.sv =====
package slc_pkg;

    // Request codes
    localparam logic [2:0] REQ_WRITE_CELL = 3'd0;
    localparam logic [2:0] REQ_LOAD_IMAGE = 3'd1;
    localparam logic [2:0] REQ_PUSH       = 3'd2;
    localparam logic [2:0] REQ_UPDATE     = 3'd3;
    localparam logic [2:0] REQ_REMOVE     = 3'd4;
    localparam logic [2:0] REQ_READ_PIXEL = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NO_SLOT = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    // Configuration register indexes
    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    localparam int MAX_SPRITES_DEF = 16;
    localparam int SCREEN_MAX_DIM  = 256;
    localparam int STORE_CELLS     = SCREEN_MAX_DIM * SCREEN_MAX_DIM;
    localparam int STORE_AW        = $clog2(STORE_CELLS);
    localparam int CELL_W          = 17;
    localparam int IMAGE_MEM_BYTES = 16384;
    localparam int IMG_AW          = $clog2(IMAGE_MEM_BYTES);

    localparam logic [8:0] SCREEN_WIDTH_RST  = 9'd80;
    localparam logic [7:0] BG_FILL           = 8'h20;
    localparam logic [7:0] CELL_MISS         = 8'hFF;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [STORE_AW-1:0] cell_idx;
        logic              oob;
        logic [7:0]        cell_x;
        logic [7:0]        cell_y;
        logic [7:0]        char_value;
        logic [13:0]       image_addr;
        logic [3:0]        sprite_slot;
        logic signed [9:0] sprite_x;
        logic signed [9:0] sprite_y;
        logic [8:0]        sprite_w;
        logic [8:0]        sprite_h;
    } cmd_t;

    typedef struct packed {
        logic signed [9:0] sx;
        logic signed [9:0] sy;
        logic [8:0]        w;
        logic [8:0]        h;
        logic [13:0]       base;
    } sprite_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       hit_sprite;
        logic [3:0] hit_slot;
        logic [1:0] status;
    } result_t;

endpackage

// ===== hw/rtl/slc_req_if.sv =====
interface slc_req_if;
    logic              valid;
    logic              ready;
    logic [2:0]        req_type;
    logic [7:0]        cell_x;
    logic [7:0]        cell_y;
    logic [7:0]        char_value;
    logic [13:0]       image_addr;
    logic [3:0]        sprite_slot;
    logic signed [9:0] sprite_x;
    logic signed [9:0] sprite_y;
    logic [8:0]        sprite_w;
    logic [8:0]        sprite_h;

    modport source (output valid, req_type, cell_x, cell_y, char_value, image_addr,
                    sprite_slot, sprite_x, sprite_y, sprite_w, sprite_h, input ready);
    modport sink (input valid, req_type, cell_x, cell_y, char_value, image_addr,
                  sprite_slot, sprite_x, sprite_y, sprite_w, sprite_h, output ready);
endinterface

// ===== hw/rtl/slc_rsp_if.sv =====
interface slc_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       hit_sprite;
    logic [3:0] hit_slot;
    logic [1:0] status;

    modport source (output valid, char_out, hit_sprite, hit_slot, status, input ready);
    modport sink (input valid, char_out, hit_sprite, hit_slot, status, output ready);
endinterface

// ===== hw/rtl/sprite_layer_compositor_core.sv =====
// Channel   Dir  Handshake     Payload
// req       in   valid/ready   req_type, cell_x, cell_y, char_value, image_addr,
//                              sprite_slot, sprite_x, sprite_y, sprite_w, sprite_h
// rsp       out  valid/ready   char_out, hit_sprite, hit_slot, status
// cfg       in   cfg_we        cfg_index, cfg_data (screen_width, screen_height)
//
// Each request passes through the EXEC and DONE states; an in-range cell write
// adds the WCELL state. A pixel read walks the sprite table top down, with an
// address step per sprite plus an image read step per covering sprite.
// After reset the background store is filled with spaces before req.ready
// rises. A two-entry queue decouples intake from execution; rsp stalls
// hold the result register and stop the back end only at its final step.
module sprite_layer_compositor_core
    import slc_pkg::*;
#(
    parameter int MAX_SPRITES = MAX_SPRITES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    slc_req_if.sink    req,
    slc_rsp_if.source  rsp,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [8:0] cfg_data
);
    logic [8:0] screen_width_reg;
    logic       clear_done;
    logic       q_full;
    logic       q_empty;
    logic       q_push;
    logic       q_pop;
    cmd_t       q_cmd;
    cmd_t       q_head;
    result_t    res;

    // Hold the screen width; writes to the height index are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg <= SCREEN_WIDTH_RST;
        end
        else if (cfg_we && (cfg_index == CFG_SCREEN_WIDTH))
        begin
            screen_width_reg <= cfg_data;
        end
    end

    slc_front u_front (
        .req          (req),
        .screen_width (screen_width_reg),
        .clear_done   (clear_done),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_cmd)
    );

    slc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    slc_back #(.MAX_SPRITES(MAX_SPRITES)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .clear_done (clear_done),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_res    (res)
    );

    assign rsp.char_out   = res.char_out;
    assign rsp.hit_sprite = res.hit_sprite;
    assign rsp.hit_slot   = res.hit_slot;
    assign rsp.status     = res.status;
endmodule

// ===== hw/rtl/slc_ram.sv =====
module slc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== hw/rtl/slc_front.sv =====
module slc_front
    import slc_pkg::*;
(
    slc_req_if.sink    req,
    input  logic [8:0] screen_width,
    input  logic       clear_done,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_cmd
);
    logic [CELL_W-1:0] cell_lin;

    // Form the linear cell index and flag cells past the store
    assign cell_lin = CELL_W'(screen_width) * CELL_W'(req.cell_y) + CELL_W'(req.cell_x);

    assign req.ready = clear_done && !q_full;
    assign q_push    = req.valid && req.ready;

    always_comb
    begin
        q_cmd.req_type    = req.req_type;
        q_cmd.cell_idx    = cell_lin[STORE_AW-1:0];
        q_cmd.oob         = (cell_lin >= CELL_W'(STORE_CELLS));
        q_cmd.cell_x      = req.cell_x;
        q_cmd.cell_y      = req.cell_y;
        q_cmd.char_value  = req.char_value;
        q_cmd.image_addr  = req.image_addr;
        q_cmd.sprite_slot = req.sprite_slot;
        q_cmd.sprite_x    = req.sprite_x;
        q_cmd.sprite_y    = req.sprite_y;
        q_cmd.sprite_w    = req.sprite_w;
        q_cmd.sprite_h    = req.sprite_h;
    end
endmodule

// ===== hw/rtl/slc_queue.sv =====
module slc_queue
    import slc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);
    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    // Hold the payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end
endmodule

// ===== hw/rtl/slc_back.sv =====
module slc_back
    import slc_pkg::*;
#(
    parameter int MAX_SPRITES = MAX_SPRITES_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_empty,
    input  cmd_t    q_head,
    output logic    q_pop,
    output logic    clear_done,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);
    localparam int CntW = $clog2(MAX_SPRITES + 1);
    localparam int IdxW = (MAX_SPRITES > 1) ? $clog2(MAX_SPRITES) : 1;
    localparam int CmpW = (CntW > 4) ? CntW : 4;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_WCELL   = 3'd2;
    localparam logic [2:0] S_PX_ADDR = 3'd3;
    localparam logic [2:0] S_PX_DATA = 3'd4;
    localparam logic [2:0] S_PX_BG   = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0]        state_reg;
    cmd_t              cur_reg;
    sprite_t           tbl_reg [MAX_SPRITES];
    logic [CntW-1:0]   count_reg;
    logic [IdxW-1:0]   k_reg;
    result_t           res_reg;
    logic              out_valid_reg;
    result_t           out_res_reg;
    logic [STORE_AW:0] clr_cnt_reg;
    logic              clear_done_reg;

    logic [CmpW-1:0]     slot_x;
    logic [CmpW-1:0]     cnt_x;
    logic [CmpW-1:0]     k_x;
    logic                slot_ok;
    logic                full;
    sprite_t             ent;
    sprite_t             new_ent;
    result_t             exec_res;
    logic signed [10:0]  dx;
    logic signed [10:0]  dy;
    logic                covered;
    logic [18:0]         prod;
    logic [IMG_AW-1:0]   pix_addr;
    logic [7:0]          bg_char;
    logic                out_load;

    logic                bg_wr_en;
    logic [STORE_AW-1:0] bg_wr_addr;
    logic [7:0]          bg_wr_data;
    logic                bg_rd_en;
    logic [7:0]          bg_rd_data;
    logic                img_wr_en;
    logic                img_rd_en;
    logic [7:0]          img_rd_data;

    assign slot_x   = CmpW'(cur_reg.sprite_slot);
    assign cnt_x    = CmpW'(count_reg);
    assign k_x      = CmpW'(k_reg);
    assign slot_ok  = slot_x < cnt_x;
    assign full     = (count_reg == CntW'(MAX_SPRITES));
    assign out_load = !out_valid_reg || out_ready;

    always_comb
    begin
        new_ent.sx   = cur_reg.sprite_x;
        new_ent.sy   = cur_reg.sprite_y;
        new_ent.w    = cur_reg.sprite_w;
        new_ent.h    = cur_reg.sprite_h;
        new_ent.base = cur_reg.image_addr;
    end

    // Classify the outcome of the current transaction
    always_comb
    begin
        exec_res = '{char_out: 8'd0, hit_sprite: 1'b0, hit_slot: 4'd0, status: ST_OK};
        case (cur_reg.req_type)
            REQ_WRITE_CELL:
            begin
                if (cur_reg.oob)
                begin
                    exec_res.char_out = CELL_MISS;
                end
            end
            REQ_PUSH:
            begin
                if (full)
                begin
                    exec_res.status = ST_FULL;
                end
                else
                begin
                    exec_res.hit_slot = cnt_x[3:0];
                end
            end
            REQ_UPDATE, REQ_REMOVE:
            begin
                if (!slot_ok)
                begin
                    exec_res.status = ST_NO_SLOT;
                end
            end
            REQ_LOAD_IMAGE, REQ_READ_PIXEL:
            begin
            end
            default:
            begin
                exec_res.status = ST_UNKNOWN;
            end
        endcase
    end

    // Test coverage of the current sprite and form its image address
    assign ent     = tbl_reg[k_reg];
    assign dx      = $signed({3'b000, cur_reg.cell_x}) - {ent.sx[9], ent.sx};
    assign dy      = $signed({3'b000, cur_reg.cell_y}) - {ent.sy[9], ent.sy};
    assign covered = !dx[10] && !dy[10] && ({1'b0, dx[9:0]} < {2'b00, ent.w})
                     && ({1'b0, dy[9:0]} < {2'b00, ent.h});
    assign prod     = ent.w * dy[9:0];
    assign pix_addr = ent.base + prod[IMG_AW-1:0] + IMG_AW'(dx[9:0]);
    assign bg_char  = cur_reg.oob ? BG_FILL : bg_rd_data;

    assign q_pop      = (state_reg == S_IDLE) && !q_empty && clear_done_reg;
    assign clear_done = clear_done_reg;
    assign out_valid  = out_valid_reg;
    assign out_res    = out_res_reg;

    // Store port steering: clearing pass first, then cell writes
    always_comb
    begin
        bg_wr_en   = 1'b0;
        bg_wr_addr = cur_reg.cell_idx;
        bg_wr_data = cur_reg.char_value;
        if (!clear_done_reg)
        begin
            bg_wr_en   = 1'b1;
            bg_wr_addr = clr_cnt_reg[STORE_AW-1:0];
            bg_wr_data = BG_FILL;
        end
        else if (state_reg == S_WCELL)
        begin
            bg_wr_en = 1'b1;
        end
    end

    assign bg_rd_en  = (state_reg == S_EXEC) && !cur_reg.oob
                       && ((cur_reg.req_type == REQ_WRITE_CELL)
                           || (cur_reg.req_type == REQ_READ_PIXEL));
    assign img_wr_en = (state_reg == S_EXEC) && (cur_reg.req_type == REQ_LOAD_IMAGE);
    assign img_rd_en = (state_reg == S_PX_ADDR) && covered;

    slc_ram #(.WIDTH(8), .DEPTH(STORE_CELLS)) u_bg_ram (
        .clk     (clk),
        .wr_en   (bg_wr_en),
        .wr_addr (bg_wr_addr),
        .wr_data (bg_wr_data),
        .rd_en   (bg_rd_en),
        .rd_addr (cur_reg.cell_idx),
        .rd_data (bg_rd_data)
    );

    slc_ram #(.WIDTH(8), .DEPTH(IMAGE_MEM_BYTES)) u_img_ram (
        .clk     (clk),
        .wr_en   (img_wr_en),
        .wr_addr (cur_reg.image_addr[IMG_AW-1:0]),
        .wr_data (cur_reg.char_value),
        .rd_en   (img_rd_en),
        .rd_addr (pix_addr),
        .rd_data (img_rd_data)
    );

    // Hold the current transaction and its result
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_head;
        end
        unique case (state_reg)
            S_EXEC:
            begin
                res_reg <= exec_res;
                case (cur_reg.req_type)
                    REQ_PUSH:
                    begin
                        if (!full)
                        begin
                            tbl_reg[count_reg[IdxW-1:0]] <= new_ent;
                        end
                    end
                    REQ_UPDATE:
                    begin
                        if (slot_ok)
                        begin
                            tbl_reg[slot_x[IdxW-1:0]] <= new_ent;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (slot_ok)
                        begin
                            for (int i = 0; i < MAX_SPRITES - 1; i++)
                            begin
                                if (CmpW'(i) >= slot_x)
                                begin
                                    tbl_reg[i] <= tbl_reg[i + 1];
                                end
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
                k_reg <= IdxW'(count_reg - 1'b1);
            end
            S_WCELL:
            begin
                res_reg.char_out <= bg_rd_data;
            end
            S_PX_ADDR:
            begin
                if (!covered)
                begin
                    if (k_reg == '0)
                    begin
                        res_reg.char_out <= bg_char;
                    end
                    else
                    begin
                        k_reg <= k_reg - 1'b1;
                    end
                end
            end
            S_PX_DATA:
            begin
                if (img_rd_data != 8'd0)
                begin
                    res_reg.char_out   <= img_rd_data;
                    res_reg.hit_sprite <= 1'b1;
                    res_reg.hit_slot   <= k_x[3:0];
                end
                else if (k_reg == '0)
                begin
                    res_reg.char_out <= bg_char;
                end
                else
                begin
                    k_reg <= k_reg - 1'b1;
                end
            end
            S_PX_BG:
            begin
                res_reg.char_out <= bg_char;
            end
            default:
            begin
            end
        endcase
        if ((state_reg == S_DONE) && out_load)
        begin
            out_res_reg <= res_reg;
        end
    end

    // Sequence the back end, the clearing pass and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            clr_cnt_reg    <= '0;
            clear_done_reg <= 1'b0;
        end
        else
        begin
            if (!clear_done_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == (STORE_AW+1)'(STORE_CELLS - 1))
                begin
                    clear_done_reg <= 1'b1;
                end
            end
            // Load the output register, or drop it once taken
            if ((state_reg == S_DONE) && out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_DONE;
                    case (cur_reg.req_type)
                        REQ_WRITE_CELL:
                        begin
                            if (!cur_reg.oob)
                            begin
                                state_reg <= S_WCELL;
                            end
                        end
                        REQ_PUSH:
                        begin
                            if (!full)
                            begin
                                count_reg <= count_reg + 1'b1;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (slot_ok)
                            begin
                                count_reg <= count_reg - 1'b1;
                            end
                        end
                        REQ_READ_PIXEL:
                        begin
                            state_reg <= (count_reg == '0) ? S_PX_BG : S_PX_ADDR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_WCELL, S_PX_BG:
                begin
                    state_reg <= S_DONE;
                end
                S_PX_ADDR:
                begin
                    if (covered)
                    begin
                        state_reg <= S_PX_DATA;
                    end
                    else if (k_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_PX_DATA:
                begin
                    if ((img_rd_data != 8'd0) || (k_reg == '0))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_PX_ADDR;
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
